@@ rtl/kws_pkg.sv @@
// Shared types and constants for the multi-keyword stream matcher.
// Used by the text memory, the compare unit and the top level; depends on nothing else.
`timescale 1ns / 1ps

package kws_pkg;

  // Width of one stream or pattern character.
  localparam int CHAR_W = 8;

  // Item opcodes as carried on the opcode field.
  typedef enum logic [2:0] {
    OP_STREAM      = 3'd0,
    OP_WRITE_CHAR  = 3'd1,
    OP_WRITE_LEN   = 3'd2,
    OP_CHECK_CLEAR = 3'd3,
    OP_CLEAR_ALL   = 3'd4
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/kws_text_mem.sv @@
// Pattern text store: one write port, one registered read port.
// Depends on kws_pkg for the character width.
`timescale 1ns / 1ps

module kws_text_mem #(
  parameter int ADDR_W = 7
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [kws_pkg::CHAR_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [kws_pkg::CHAR_W-1:0] rd_data
);

  logic [kws_pkg::CHAR_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/kws_match_unit.sv @@
// Shared compare unit: checks one pattern's expected character against the stream.
// Depends on kws_pkg for the character width.
`timescale 1ns / 1ps

module kws_match_unit #(
  parameter int MAX_LEN = 16,
  parameter int LW      = 5
) (
  input  logic [kws_pkg::CHAR_W-1:0] text_char,
  input  logic [kws_pkg::CHAR_W-1:0] stream_char,
  input  logic [LW-1:0]              progress,
  input  logic [LW-1:0]              length,
  output logic [LW-1:0]              progress_next,
  output logic                       hit
);

  logic advance;

  // Advance on a character match while progress is below MAX_LEN, otherwise fall back to the start.
  assign advance       = (progress < LW'(MAX_LEN)) && (text_char == stream_char);
  assign progress_next = advance ? progress + LW'(1) : '0;

  // The pattern completes when its progress reaches its length.
  assign hit = (length != '0) && (progress_next == length);

endmodule

@@ rtl/multi_keyword_stream_matcher.sv @@
// Multi-keyword stream matcher.
// Input channel (in_valid / in_stall) carries one item per transaction: a stream
// character, a pattern character write, a pattern length write, a read-and-clear
// of one match flag, or a clear of all flags. Every item gives exactly one result
// transaction on the output channel (out_valid / out_stall).
// A stream character is checked against the patterns in use by one shared compare
// unit, one pattern per cycle, with the pattern text read from a memory with one
// write port and one registered read port, in the cycle before the compare.
// The scan ends after the last pattern in use, or earlier when a pattern
// completes; every other item goes straight from acceptance to the finish state.
// The next item is accepted in the cycle after the result has moved to the output
// register, so the block takes no new item while one is still in progress.
// The output register holds a finished result while the receiver stalls; the
// block then finishes the next item and waits with it until the register frees.
// The configuration channel (cfg_valid / cfg_ready) writes pattern_count and is
// always ready. Synchronous reset clears lengths, progress, flags and the count;
// pattern text is undefined until written, and no clearing pass is needed.
`timescale 1ns / 1ps

module multi_keyword_stream_matcher #(
  parameter int PATTERNS = 8,
  parameter int MAX_LEN  = 16
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,
  // Input item channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [2:0] pattern_id,
  input  logic [3:0] position,
  input  logic [7:0] char_value,
  input  logic [4:0] length_value,
  // Result channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic       match_found,
  output logic [2:0] match_index,
  output logic       flag_read,
  output logic [7:0] all_flags
);

  localparam int IW     = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int NW     = $clog2(PATTERNS + 1);
  localparam int PW     = $clog2(MAX_LEN);
  localparam int LW     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = IW + PW;

  kws_pkg::state_t state, state_next;

  // Configuration and architectural state.
  logic [3:0]                 pattern_count;
  logic [LW-1:0]              lengths  [PATTERNS];
  logic [LW-1:0]              progress [PATTERNS];
  logic [PATTERNS-1:0]        flags;

  // Item context and pending result.
  logic [kws_pkg::CHAR_W-1:0] ch_q;
  logic [NW-1:0]              n_q;
  logic                       res_found;
  logic [2:0]                 res_which;
  logic                       res_fread;

  // Scan pipeline: issue stage and compare stage.
  logic [NW-1:0]              iss;
  logic [IW-1:0]              iss_idx;
  logic                       iss_ok;
  logic                       cmp_valid;
  logic [IW-1:0]              cmp_idx;
  logic [LW-1:0]              cmp_p;
  logic [LW-1:0]              cmp_len;

  // Compare unit and memory signals.
  logic [kws_pkg::CHAR_W-1:0] text_rd;
  logic [LW-1:0]              p_new;
  logic                       hit;
  logic                       cmp_update;
  logic                       match_now;

  // Decoded input item.
  logic                       accept;
  logic                       id_ok;
  logic                       pos_ok;
  logic [IW-1:0]              id_idx;
  logic [LW-1:0]              len_sat;
  logic [5:0]                 count_ext;
  logic [NW-1:0]              n_in;
  logic                       mem_wr_en;
  logic                       out_free;
  logic                       finish_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != kws_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;

  // Field decoding and range checks.
  assign id_ok     = 6'(pattern_id) < 6'(PATTERNS);
  assign pos_ok    = 7'(position) < 7'(MAX_LEN);
  assign id_idx    = IW'(pattern_id);
  assign len_sat   = (7'(length_value) > 7'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(length_value);
  assign count_ext = 6'(pattern_count);
  assign n_in      = (count_ext > 6'(PATTERNS)) ? NW'(PATTERNS) : NW'(count_ext);
  assign mem_wr_en = accept && (opcode == kws_pkg::OP_WRITE_CHAR) && id_ok && pos_ok;

  // Issue stage selects the next pattern in use.
  assign iss_idx = iss[IW-1:0];
  assign iss_ok  = iss < n_q;

  kws_text_mem #(
    .ADDR_W (ADDR_W)
  ) u_text_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr ({id_idx, PW'(position)}),
    .wr_data (char_value),
    .rd_addr ({iss_idx, progress[iss_idx][PW-1:0]}),
    .rd_data (text_rd)
  );

  kws_match_unit #(
    .MAX_LEN (MAX_LEN),
    .LW      (LW)
  ) u_match_unit (
    .text_char     (text_rd),
    .stream_char   (ch_q),
    .progress      (cmp_p),
    .length        (cmp_len),
    .progress_next (p_new),
    .hit           (hit)
  );

  assign cmp_update = (state == kws_pkg::ST_SCAN) && cmp_valid && (cmp_len != '0);
  assign match_now  = cmp_update && hit;
  assign out_free   = !out_valid || !out_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kws_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and output register load.
  always_comb begin
    state_next  = state;
    finish_load = 1'b0;
    case (state)
      kws_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (opcode == kws_pkg::OP_STREAM) ? kws_pkg::ST_SCAN : kws_pkg::ST_FINISH;
        end
      end
      kws_pkg::ST_SCAN: begin
        // The last compare writes back at the same edge that leaves the scan.
        if (match_now || !iss_ok) begin
          state_next = kws_pkg::ST_FINISH;
        end
      end
      kws_pkg::ST_FINISH: begin
        if (out_free) begin
          finish_load = 1'b1;
          state_next  = kws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kws_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state: count, lengths, progress, flags and pipeline valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count <= '0;
      flags         <= '0;
      cmp_valid     <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < PATTERNS; i++) begin
        lengths[i]  <= '0;
        progress[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        pattern_count <= cfg_data;
      end

      // Items other than stream characters act at acceptance.
      if (accept) begin
        cmp_valid <= 1'b0;
        case (kws_pkg::op_t'(opcode))
          kws_pkg::OP_WRITE_LEN: begin
            if (id_ok) begin
              lengths[id_idx]  <= len_sat;
              progress[id_idx] <= '0;
            end
          end
          kws_pkg::OP_CHECK_CLEAR: begin
            if (id_ok) begin
              flags[id_idx] <= 1'b0;
            end
          end
          kws_pkg::OP_CLEAR_ALL: begin
            flags <= '0;
          end
          default: begin
          end
        endcase
      end

      // Compare stage writes back progress; a hit clears all of it.
      if (cmp_update) begin
        if (hit) begin
          flags[cmp_idx] <= 1'b1;
          for (int i = 0; i < PATTERNS; i++) begin
            progress[i] <= '0;
          end
        end else begin
          progress[cmp_idx] <= p_new;
        end
      end

      // Issue stage hands the next pattern to the compare stage.
      if (state == kws_pkg::ST_SCAN) begin
        cmp_valid <= iss_ok && !match_now;
      end

      // Output register.
      if (finish_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers of the scan and of the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q      <= char_value;
      n_q       <= n_in;
      iss       <= '0;
      res_found <= 1'b0;
      res_which <= '0;
      res_fread <= (opcode == kws_pkg::OP_CHECK_CLEAR) && id_ok && flags[id_idx];
    end
    if ((state == kws_pkg::ST_SCAN) && iss_ok) begin
      cmp_idx <= iss_idx;
      cmp_p   <= progress[iss_idx];
      cmp_len <= lengths[iss_idx];
      iss     <= iss + NW'(1);
    end
    if (match_now) begin
      res_found <= 1'b1;
      res_which <= 3'(cmp_idx);
    end
    if (finish_load) begin
      match_found <= res_found;
      match_index <= res_which;
      flag_read   <= res_fread;
      all_flags   <= 8'(flags);
    end
  end

endmodule

@@ rtl/kws_checker.sv @@
// Port-level checks for the multi-keyword stream matcher, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module kws_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       match_found,
  input logic [2:0] match_index,
  input logic       flag_read,
  input logic [7:0] all_flags
);

  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again in the cycle after an acceptance");

  // A reported match has its sticky flag set in the same result.
  a_match_sets_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_found |-> all_flags[match_index])
    else $error("match reported without its flag set");

  // Without a match the index reads as zero, and a flag read never comes with a match.
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !match_found |-> match_index == 3'd0)
    else $error("match index not zero without a match");

  a_flag_read_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(flag_read && match_found))
    else $error("flag read and match reported in one result");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(all_flags) && $stable(match_found))
    else $error("result changed while stalled");

endmodule

bind multi_keyword_stream_matcher kws_checker u_kws_checker (.*);
